[rtl/cbw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbw_pkg: shared types and constants for the clipped RGB565 blit writer
// Holds the register map, field widths, the tile walker's result type and
// the colour widening function.
// ----------------------------------------------------------------------------
package cbw_pkg;

    localparam int unsigned COORD_W = 12;
    localparam int unsigned POS_W   = 13;
    localparam int unsigned COUNT_W = 11;
    localparam int unsigned FB_W    = 11;
    localparam int unsigned ADDR_W  = 20;
    localparam int unsigned PIX_W   = 16;
    localparam int unsigned COLOR_W = 24;

    localparam logic [COORD_W-1:0] SPAN_LIMIT = 12'd2048;
    localparam logic [4:0]         MASK5      = 5'h1F;
    localparam logic [5:0]         MASK6      = 6'h3F;

    typedef enum logic {
        REG_FB_WIDTH  = 1'b0,
        REG_FB_HEIGHT = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic                     emit;
        logic signed [POS_W-1:0]  col;
        logic signed [POS_W-1:0]  row;
        logic                     done;
    } walk_t;

    function automatic logic [COLOR_W-1:0] widen565(input logic [PIX_W-1:0] c);
        logic [4:0] r5;
        logic [5:0] g6;
        logic [4:0] b5;
        r5 = c[15:11] & MASK5;
        g6 = c[10:5] & MASK6;
        b5 = c[4:0] & MASK5;
        return {r5, r5[4:2], g6, g6[5:4], b5, b5[4:2]};
    endfunction

endpackage

[rtl/clipped_rgb565_blit_writer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_rgb565_blit_writer_top: clipped RGB565 to XRGB8888 blit writer
// Walks tiles of RGB565 pixels, clips them against the framebuffer and gives
// one framebuffer write beat per tile pixel.
//
// Channel  Direction  Beat contents
// s_       in         tdata: tile_x, tile_y, tile_w, tile_h, pixel; tuser: tile_start
// m_       out        tdata: address, color; tuser: write_enable; tlast: tile_done
// apb      in         fb_width at 0x0, fb_height at 0x4
//
// One pixel beat is taken every cycle unless a stall on m_ has filled both
// stages; each result is held in the position register, then goes through
// the address multiplier into the output register.
// Reset is synchronous and active low; it empties both stages.
// A stall on m_ holds the output register; s_tready drops in the same cycle
// once the position stage is also full, so up to two beats wait inside.
// ----------------------------------------------------------------------------
module clipped_rgb565_blit_writer_top #(
    parameter int unsigned MAX_FB_DIM = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // tile_x[11:0], tile_y[23:12], tile_w[35:24], tile_h[47:36], pixel[63:48]
    input  logic [63:0] s_tdata,
    // tile_start[0]
    input  logic        s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // address[19:0], color[43:20], zero fill [47:44]
    output logic [47:0] m_tdata,
    // write_enable[0]
    output logic        m_tuser,
    output logic        m_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [cbw_pkg::FB_W-1:0] FB_RESET =
        cbw_pkg::FB_W'((1024 > MAX_FB_DIM) ? MAX_FB_DIM : 1024);

    logic [cbw_pkg::FB_W-1:0] fb_width_reg, fb_width_next;
    logic [cbw_pkg::FB_W-1:0] fb_height_reg, fb_height_next;
    logic [cbw_pkg::FB_W-1:0] wr_value;
    logic                     wr_en;

    logic                     s_accept;
    logic                     advance;
    cbw_pkg::walk_t           walk;

    logic                             p1_valid_reg, p1_valid_next;
    logic signed [cbw_pkg::POS_W-1:0] p1_col_reg, p1_row_reg;
    logic [cbw_pkg::PIX_W-1:0]        p1_pixel_reg;
    logic                             p1_done_reg;

    logic                             vis;
    logic [2*cbw_pkg::FB_W-1:0]       prod;
    logic [2*cbw_pkg::FB_W-1:0]       lin;
    logic                             out_valid_reg, out_valid_next;
    logic                             out_we_reg;
    logic [cbw_pkg::ADDR_W-1:0]       out_addr_reg;
    logic [cbw_pkg::COLOR_W-1:0]      out_color_reg;
    logic                             out_last_reg;

    // Configuration port.
    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite && pready;
    assign wr_value = (32'(pwdata[cbw_pkg::FB_W-1:0]) > MAX_FB_DIM)
                    ? cbw_pkg::FB_W'(MAX_FB_DIM) : pwdata[cbw_pkg::FB_W-1:0];

    always_comb begin
        fb_width_next  = fb_width_reg;
        fb_height_next = fb_height_reg;
        if (wr_en) begin
            case (cbw_pkg::reg_index_t'(paddr[2]))
                cbw_pkg::REG_FB_WIDTH:  fb_width_next  = wr_value;
                cbw_pkg::REG_FB_HEIGHT: fb_height_next = wr_value;
                default:                fb_width_next  = fb_width_reg;
            endcase
        end
    end

    always_comb begin
        case (cbw_pkg::reg_index_t'(paddr[2]))
            cbw_pkg::REG_FB_WIDTH:  prdata = 32'(fb_width_reg);
            cbw_pkg::REG_FB_HEIGHT: prdata = 32'(fb_height_reg);
            default:                prdata = '0;
        endcase
    end

    // Pipeline control.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !p1_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    cbw_tile_walker u_walker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (s_accept),
        .tile_start (s_tuser),
        .tile_x     (s_tdata[11:0]),
        .tile_y     (s_tdata[23:12]),
        .tile_w     (s_tdata[35:24]),
        .tile_h     (s_tdata[47:36]),
        .walk       (walk)
    );

    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (s_tready) begin
            p1_valid_next = s_accept && walk.emit;
        end
    end

    // Clipping, address and colour.
    always_comb begin
        vis  = !p1_col_reg[cbw_pkg::POS_W-1] && !p1_row_reg[cbw_pkg::POS_W-1]
            && (p1_col_reg[cbw_pkg::POS_W-2:0] < {1'b0, fb_width_reg})
            && (p1_row_reg[cbw_pkg::POS_W-2:0] < {1'b0, fb_height_reg});
        prod = {{cbw_pkg::FB_W{1'b0}}, p1_row_reg[cbw_pkg::FB_W-1:0]}
             * {{cbw_pkg::FB_W{1'b0}}, fb_width_reg};
        lin  = prod + {{cbw_pkg::FB_W{1'b0}}, p1_col_reg[cbw_pkg::FB_W-1:0]};
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fb_width_reg  <= FB_RESET;
            fb_height_reg <= FB_RESET;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            fb_width_reg  <= fb_width_next;
            fb_height_reg <= fb_height_next;
            p1_valid_reg  <= p1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_col_reg   <= walk.col;
            p1_row_reg   <= walk.row;
            p1_pixel_reg <= s_tdata[63:48];
            p1_done_reg  <= walk.done;
        end
        if (advance && p1_valid_reg) begin
            out_we_reg    <= vis;
            out_addr_reg  <= vis ? lin[cbw_pkg::ADDR_W-1:0] : '0;
            out_color_reg <= vis ? cbw_pkg::widen565(p1_pixel_reg) : '0;
            out_last_reg  <= p1_done_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_we_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'b0000, out_color_reg, out_addr_reg};

`ifndef SYNTHESIS
    a_clipped_beat_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("clipped beat carries a non-zero address or colour");

    a_empty_tile_no_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tuser && (s_tdata[35:24] == '0 || s_tdata[47:36] == '0)
        |=> !p1_valid_reg)
        else $error("empty tile produced a pixel in the pipeline");

    a_stage_held: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg && !advance |=> p1_valid_reg && $stable(p1_col_reg)
        && $stable(p1_row_reg) && $stable(p1_pixel_reg))
        else $error("position stage lost or changed a pixel during a stall");

    a_visible_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && p1_valid_reg && vis |=> m_tuser && m_tvalid)
        else $error("visible pixel did not reach the output as a write");
`endif

endmodule

[rtl/cbw_tile_walker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbw_tile_walker: tile geometry and column/row counting
// Captures the geometry on the first pixel of a tile, keeps the column and
// row counters and gives the framebuffer position of each accepted pixel.
// ----------------------------------------------------------------------------
module cbw_tile_walker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               accept,
    input  logic                               tile_start,
    input  logic [cbw_pkg::COORD_W-1:0]        tile_x,
    input  logic [cbw_pkg::COORD_W-1:0]        tile_y,
    input  logic [cbw_pkg::COORD_W-1:0]        tile_w,
    input  logic [cbw_pkg::COORD_W-1:0]        tile_h,
    output cbw_pkg::walk_t                     walk
);

    logic                          active_reg,   active_next;
    logic [cbw_pkg::COORD_W-1:0]   origin_x_reg, origin_x_next;
    logic [cbw_pkg::COORD_W-1:0]   origin_y_reg, origin_y_next;
    logic [cbw_pkg::COORD_W-1:0]   span_w_reg,   span_w_next;
    logic [cbw_pkg::COORD_W-1:0]   span_h_reg,   span_h_next;
    logic [cbw_pkg::COUNT_W-1:0]   col_count_reg, col_count_next;
    logic [cbw_pkg::COUNT_W-1:0]   row_count_reg, row_count_next;

    logic [cbw_pkg::COORD_W-1:0]   ox, oy, sw, sh;
    logic [cbw_pkg::COUNT_W-1:0]   cc, rc;
    logic [cbw_pkg::COORD_W-1:0]   cc_inc, rc_inc;
    logic                          emit, done;

    always_comb begin
        ox = tile_start ? tile_x : origin_x_reg;
        oy = tile_start ? tile_y : origin_y_reg;
        sw = tile_start ? ((tile_w > cbw_pkg::SPAN_LIMIT) ? cbw_pkg::SPAN_LIMIT : tile_w)
                        : span_w_reg;
        sh = tile_start ? ((tile_h > cbw_pkg::SPAN_LIMIT) ? cbw_pkg::SPAN_LIMIT : tile_h)
                        : span_h_reg;
        cc = tile_start ? '0 : col_count_reg;
        rc = tile_start ? '0 : row_count_reg;
        cc_inc = {1'b0, cc} + 12'd1;
        rc_inc = {1'b0, rc} + 12'd1;
        emit = tile_start ? ((sw != '0) && (sh != '0)) : active_reg;
        done = (cc_inc == sw) && (rc_inc == sh);

        walk.emit = emit;
        walk.col  = $signed({ox[cbw_pkg::COORD_W-1], ox}) + $signed({2'b00, cc});
        walk.row  = $signed({oy[cbw_pkg::COORD_W-1], oy}) + $signed({2'b00, rc});
        walk.done = done;
    end

    always_comb begin
        active_next    = active_reg;
        origin_x_next  = origin_x_reg;
        origin_y_next  = origin_y_reg;
        span_w_next    = span_w_reg;
        span_h_next    = span_h_reg;
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (accept) begin
            if (tile_start) begin
                origin_x_next = ox;
                origin_y_next = oy;
                span_w_next   = sw;
                span_h_next   = sh;
            end
            if (emit) begin
                active_next = !done;
                if (done) begin
                    col_count_next = '0;
                    row_count_next = '0;
                end else if (cc_inc >= sw) begin
                    col_count_next = '0;
                    row_count_next = rc_inc[cbw_pkg::COUNT_W-1:0];
                end else begin
                    col_count_next = cc_inc[cbw_pkg::COUNT_W-1:0];
                    row_count_next = rc;
                end
            end else if (tile_start) begin
                active_next    = 1'b0;
                col_count_next = '0;
                row_count_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            span_w_reg    <= '0;
            span_h_reg    <= '0;
            col_count_reg <= '0;
            row_count_reg <= '0;
        end else begin
            active_reg    <= active_next;
            origin_x_reg  <= origin_x_next;
            origin_y_reg  <= origin_y_next;
            span_w_reg    <= span_w_next;
            span_h_reg    <= span_h_next;
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

endmodule

[bench/clipped_rgb565_blit_writer_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_rgb565_blit_writer_top_tb: self-checking bench for the blit writer
// A queue of tile pixel beats is streamed into the block in random bursts.
// The block's output is checked against a tile walker kept in the bench.
// That walker clips each pixel, works out the framebuffer address, widens
// RGB565 to XRGB8888 and flags the last pixel of each tile.
// The framebuffer size is reprogrammed over APB between phases, including
// zero, the largest size and values that must be clamped.
// The result channel stalls on its own pattern and once holds off long
// enough to back the block up.
// ----------------------------------------------------------------------------
module clipped_rgb565_blit_writer_top_tb;

    localparam int MAX_DIM     = 1024;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 8;

    typedef struct packed {
        logic        start;
        logic [11:0] x;
        logic [11:0] y;
        logic [11:0] w;
        logic [11:0] h;
        logic [15:0] pix;
    } tile_pixel_t;

    typedef struct packed {
        logic        we;
        logic [19:0] addr;
        logic [23:0] color;
        logic        done;
    } fb_write_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [63:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    clipped_rgb565_blit_writer_top #(
        .MAX_FB_DIM(MAX_DIM)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #5 aclk = ~aclk;

    tile_pixel_t pixel_beats[$];
    fb_write_t   fb_writes_due[$];
    int          queued_total = 0;
    int          mismatches = 0;

    // Tile walker state and framebuffer size as the block should hold them.
    logic [10:0] fb_cols = 11'd1024;
    logic [10:0] fb_rows = 11'd1024;
    logic        tile_live = 1'b0;
    logic [11:0] org_x = '0;
    logic [11:0] org_y = '0;
    logic [11:0] span_w = '0;
    logic [11:0] span_h = '0;
    logic [10:0] col_cnt = '0;
    logic [10:0] row_cnt = '0;

    function automatic logic [23:0] expand_565_color(input logic [15:0] c);
        int r5;
        int g6;
        int b5;
        r5 = (c >> 11) & 'h1F;
        g6 = (c >> 5) & 'h3F;
        b5 = c & 'h1F;
        return 24'((((r5 << 3) | (r5 >> 2)) << 16) | (((g6 << 2) | (g6 >> 4)) << 8)
                   | ((b5 << 3) | (b5 >> 2)));
    endfunction

    function automatic logic [10:0] clamp_fb_dim(input logic [31:0] v);
        logic [10:0] d;
        d = v[10:0];
        return (d > MAX_DIM) ? 11'(MAX_DIM) : d;
    endfunction

    task automatic walk_pixel(input tile_pixel_t b);
        int        col;
        int        row;
        logic      vis;
        logic      last;
        fb_write_t wr;
        if (b.start) begin
            org_x   = b.x;
            org_y   = b.y;
            span_w  = (b.w > cbw_pkg::SPAN_LIMIT) ? cbw_pkg::SPAN_LIMIT : b.w;
            span_h  = (b.h > cbw_pkg::SPAN_LIMIT) ? cbw_pkg::SPAN_LIMIT : b.h;
            col_cnt = '0;
            row_cnt = '0;
            if (span_w == 0 || span_h == 0) begin
                tile_live = 1'b0;
                return;
            end
            tile_live = 1'b1;
        end else if (!tile_live) begin
            return;
        end
        col  = int'($signed(org_x)) + int'(col_cnt);
        row  = int'($signed(org_y)) + int'(row_cnt);
        vis  = col >= 0 && row >= 0 && col < int'(fb_cols) && row < int'(fb_rows);
        last = (int'(col_cnt) + 1 == int'(span_w)) && (int'(row_cnt) + 1 == int'(span_h));
        wr.we    = vis;
        wr.addr  = vis ? 20'(row * int'(fb_cols) + col) : '0;
        wr.color = vis ? expand_565_color(b.pix) : '0;
        wr.done  = last;
        fb_writes_due.push_back(wr);
        if (last) begin
            tile_live = 1'b0;
            col_cnt   = '0;
            row_cnt   = '0;
        end else if (int'(col_cnt) + 1 >= int'(span_w)) begin
            col_cnt = '0;
            row_cnt = row_cnt + 11'd1;
        end else begin
            col_cnt = col_cnt + 11'd1;
        end
    endtask

    // Sender: bursts of random length with random gaps, or none when steady.
    tile_pixel_t held_beat;
    int          burst_left = 0;
    int          gap_left = 0;
    bit          tx_steady = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                walk_pixel(held_beat);
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pixel_beats.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else begin
                    held_beat = pixel_beats.pop_front();
                    s_tdata  <= {held_beat.pix, held_beat.h, held_beat.w, held_beat.y,
                                 held_beat.x};
                    s_tuser  <= held_beat.start;
                    s_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = tx_steady ? 0 : $urandom_range(0, 6);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // Receiver: changes its stall pattern every so often; a long hold-off
    // can be requested by bumping hold_req.
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int rx_cycles = 0;
    int rx_style = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            rx_cycles++;
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = 120;
            end
            if (rx_cycles % 150 == 0) begin
                rx_style = $urandom_range(0, 3);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (rx_style)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= ($urandom_range(0, 1) != 0);
                    default: m_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // Result checker and watchdog.
    fb_write_t seen_wr;
    fb_write_t due_wr;
    int        quiet_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_wr = '{m_tuser, m_tdata[19:0], m_tdata[43:20], m_tlast};
            if (fb_writes_due.size() == 0) begin
                $error("unexpected result beat: addr %0h color %0h", seen_wr.addr,
                       seen_wr.color);
                mismatches++;
            end else begin
                due_wr = fb_writes_due.pop_front();
                if (seen_wr.we !== due_wr.we) begin
                    $error("write_enable: expected %0d, got %0d", due_wr.we, seen_wr.we);
                    mismatches++;
                end
                if (seen_wr.addr !== due_wr.addr) begin
                    $error("address: expected %0h, got %0h", due_wr.addr, seen_wr.addr);
                    mismatches++;
                end
                if (seen_wr.color !== due_wr.color) begin
                    $error("color: expected %0h, got %0h", due_wr.color, seen_wr.color);
                    mismatches++;
                end
                if (seen_wr.done !== due_wr.done) begin
                    $error("tile_done: expected %0d, got %0d", due_wr.done, seen_wr.done);
                    mismatches++;
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("clipped_rgb565_blit_writer_top_tb failed");
                $finish;
            end
        end
    end

    task automatic push_beat(input logic start, input logic [11:0] x, input logic [11:0] y,
                             input logic [11:0] w, input logic [11:0] h,
                             input logic [15:0] pix);
        pixel_beats.push_back('{start, x, y, w, h, pix});
        queued_total++;
    endtask

    task automatic push_noise();
        push_beat(1'b0, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                  16'($urandom));
    endtask

    // A tile start beat followed by count-1 further pixels.
    task automatic push_tile(input int x, input int y, input int w, input int h,
                             input int count);
        push_beat(1'b1, 12'(x), 12'(y), 12'(w), 12'(h), 16'($urandom));
        for (int i = 1; i < count; i++) begin
            push_noise();
        end
    endtask

    task automatic random_phase(input int n_items);
        int target;
        int pick;
        int w;
        int h;
        int x;
        int y;
        int count;
        target = queued_total + n_items;
        while (queued_total < target) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                push_noise();
            end else if (pick == 1) begin
                if ($urandom_range(0, 1) != 0) begin
                    push_beat(1'b1, 12'($urandom), 12'($urandom), 12'd0, 12'($urandom),
                              16'($urandom));
                end else begin
                    push_beat(1'b1, 12'($urandom), 12'($urandom), 12'($urandom), 12'd0,
                              16'($urandom));
                end
            end else if (pick == 2) begin
                w = ($urandom_range(0, 1) != 0) ? $urandom_range(2048, 4095) : $urandom;
                push_tile($urandom, $urandom, w, $urandom, $urandom_range(1, 6));
            end else begin
                w = $urandom_range(1, 10);
                h = $urandom_range(1, 5);
                x = $urandom_range(0, int'(fb_cols) + 12) - 6;
                y = $urandom_range(0, int'(fb_rows) + 12) - 6;
                if ($urandom_range(0, 7) == 0) begin
                    x = $urandom;
                    y = $urandom;
                end
                count = w * h;
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    count = $urandom_range(1, w * h);
                end else if (pick == 1) begin
                    count = w * h + $urandom_range(1, 3);
                end
                push_tile(x, y, w, h, count);
            end
        end
    endtask

    task automatic wait_idle();
        do begin
            @(negedge aclk);
        end while (pixel_beats.size() != 0 || s_tvalid || fb_writes_due.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic apb_write(input cbw_pkg::reg_index_t idx, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == cbw_pkg::REG_FB_WIDTH) begin
            fb_cols = clamp_fb_dim(value);
        end else begin
            fb_rows = clamp_fb_dim(value);
        end
    endtask

    logic [31:0] cfg_w;
    logic [31:0] cfg_h;

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed beats against the reset framebuffer size.
        push_noise();
        push_beat(1'b1, 12'd5, 12'd5, 12'd0, 12'd3, 16'h1234);
        push_noise();
        push_beat(1'b1, 12'd5, 12'd5, 12'd4, 12'd0, 16'h4321);
        push_beat(1'b1, 12'hFFF, 12'hFFF, 12'd2, 12'd2, 16'hF800);
        push_beat(1'b0, 12'd0, 12'd0, 12'd0, 12'd0, 16'h07E0);
        push_beat(1'b0, 12'd0, 12'd0, 12'd0, 12'd0, 16'h001F);
        push_beat(1'b0, 12'd0, 12'd0, 12'd0, 12'd0, 16'hFFFF);
        push_beat(1'b1, 12'd0, 12'd0, 12'd1, 12'd2, 16'h0000);
        push_beat(1'b0, 12'd0, 12'd0, 12'd0, 12'd0, 16'hFFFF);
        push_beat(1'b1, 12'd1023, 12'd1023, 12'd2, 12'd1, 16'hFFFF);
        push_beat(1'b0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 16'hFFFF);
        push_beat(1'b1, 12'h800, 12'h7FF, 12'd1, 12'd2, 16'hA5A5);
        push_noise();
        push_tile(0, 0, 4095, 4095, 3);
        push_tile(1020, 0, 2048, 1, 3);
        push_tile(3, 4, 3, 1, 3);
        push_noise();
        wait_idle();

        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: begin
                    cfg_w = 32'd0;
                    cfg_h = 32'd5;
                end
                1: begin
                    cfg_w = ($urandom & ~32'h7FF) | 32'd2047;
                    cfg_h = 32'd1025;
                end
                2: begin
                    cfg_w = 32'd1;
                    cfg_h = 32'd1;
                end
                3: begin
                    cfg_w = 32'd1024;
                    cfg_h = 32'd1;
                end
                4: begin
                    cfg_w = 32'd1;
                    cfg_h = 32'd0;
                end
                5: begin
                    cfg_w = 32'd1024;
                    cfg_h = 32'd1024;
                end
                default: begin
                    cfg_w = ($urandom & ~32'h7FF) | 32'($urandom_range(1, 48));
                    cfg_h = ($urandom & ~32'h7FF) | 32'($urandom_range(1, 48));
                end
            endcase
            apb_write(cbw_pkg::REG_FB_WIDTH, cfg_w);
            apb_write(cbw_pkg::REG_FB_HEIGHT, cfg_h);
            if (ph == 6) begin
                tx_steady = 1'b1;
                random_phase(160);
                @(negedge aclk);
                hold_req++;
            end else begin
                random_phase(140);
            end
            wait_idle();
            tx_steady = 1'b0;
        end

        if (mismatches == 0) begin
            $display("clipped_rgb565_blit_writer_top_tb passed");
        end else begin
            $display("clipped_rgb565_blit_writer_top_tb failed");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/cbw_pkg.sv
rtl/cbw_tile_walker.sv
rtl/clipped_rgb565_blit_writer_top.sv
bench/clipped_rgb565_blit_writer_top_tb.sv
